// ===== hdl/sort_and_count_keys_defines.svh =====
// Assertion macros used by the sort_and_count_keys datapath.
`ifndef SORT_AND_COUNT_KEYS_DEFINES_SVH
`define SORT_AND_COUNT_KEYS_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SCK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SCK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/sck_pkg.sv =====
// Shared types and operation codes for sort_and_count_keys.
`timescale 1ns / 1ps
package sck_pkg;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE      = 5'd0;
    localparam op_t OP_CLR       = 5'd1;
    localparam op_t OP_LOAD      = 5'd2;
    localparam op_t OP_SORT_INIT = 5'd3;
    localparam op_t OP_READ_SORT = 5'd4;
    localparam op_t OP_EVAL_SORT = 5'd5;
    localparam op_t OP_SW_WA     = 5'd6;
    localparam op_t OP_SW_WB     = 5'd7;
    localparam op_t OP_SW_LA     = 5'd8;
    localparam op_t OP_SW_LB     = 5'd9;
    localparam op_t OP_NEXT_PAIR = 5'd10;
    localparam op_t OP_NEW_PASS  = 5'd11;
    localparam op_t OP_SORTED    = 5'd12;
    localparam op_t OP_SCAN_INIT = 5'd13;
    localparam op_t OP_READ_SCAN = 5'd14;
    localparam op_t OP_EVAL_SCAN = 5'd15;
    localparam op_t OP_READ_EMIT = 5'd16;
    localparam op_t OP_EMIT      = 5'd17;
    localparam op_t OP_END_MARK  = 5'd18;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        op_t op;
    } sck_cmd_t;

    typedef struct packed {
        logic room;
        logic more_room;
        logic wlast;
        logic ne;
        logic gt;
        logic few;
        logic pair_last;
        logic swapped;
        logic sorted;
        logic at_end;
        logic scan_more;
        logic fin;
        logic out_free;
    } sck_status_t;

endpackage

// ===== hdl/sck_ctrl.sv =====
// Controller state machine for sort_and_count_keys.
`timescale 1ns / 1ps
module sck_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                s_tready,
    input  sck_pkg::sck_status_t st,
    output sck_pkg::sck_cmd_t   cmd
);

    localparam logic [4:0] ST_CLR        = 5'd0;
    localparam logic [4:0] ST_IDLE       = 5'd1;
    localparam logic [4:0] ST_SORT_START = 5'd2;
    localparam logic [4:0] ST_CRD        = 5'd3;
    localparam logic [4:0] ST_CEV        = 5'd4;
    localparam logic [4:0] ST_SRD        = 5'd5;
    localparam logic [4:0] ST_SWA        = 5'd6;
    localparam logic [4:0] ST_SWB        = 5'd7;
    localparam logic [4:0] ST_SLA        = 5'd8;
    localparam logic [4:0] ST_SLB        = 5'd9;
    localparam logic [4:0] ST_NEXT       = 5'd10;
    localparam logic [4:0] ST_SORT_DONE  = 5'd11;
    localparam logic [4:0] ST_SCAN_START = 5'd12;
    localparam logic [4:0] ST_SC_CHK     = 5'd13;
    localparam logic [4:0] ST_SC_RD      = 5'd14;
    localparam logic [4:0] ST_SC_EV      = 5'd15;
    localparam logic [4:0] ST_EMIT_RD    = 5'd16;
    localparam logic [4:0] ST_EMIT       = 5'd17;
    localparam logic [4:0] ST_END        = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sck_pkg::OP_NONE;
        case (state_reg)
            ST_CLR:
            begin
                if (!st.room)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = sck_pkg::OP_CLR;
                    if (st.wlast)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == sck_pkg::CMD_LOAD)
                    begin
                        cmd.op = sck_pkg::OP_LOAD;
                        if (s_tlast && st.room && st.more_room)
                        begin
                            state_next = ST_CLR;
                        end
                    end
                    else
                    begin
                        state_next = st.sorted ? ST_SCAN_START : ST_SORT_START;
                    end
                end
            end
            ST_SORT_START:
            begin
                if (st.few)
                begin
                    state_next = ST_SORT_DONE;
                end
                else
                begin
                    cmd.op     = sck_pkg::OP_SORT_INIT;
                    state_next = ST_CRD;
                end
            end
            ST_CRD:
            begin
                cmd.op     = sck_pkg::OP_READ_SORT;
                state_next = ST_CEV;
            end
            ST_CEV:
            begin
                cmd.op = sck_pkg::OP_EVAL_SORT;
                if (st.gt)
                begin
                    state_next = ST_SRD;
                end
                else if (st.ne || st.wlast)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_CRD;
                end
            end
            ST_SRD:
            begin
                cmd.op     = sck_pkg::OP_READ_SORT;
                state_next = ST_SWA;
            end
            ST_SWA:
            begin
                cmd.op     = sck_pkg::OP_SW_WA;
                state_next = ST_SWB;
            end
            ST_SWB:
            begin
                cmd.op     = sck_pkg::OP_SW_WB;
                state_next = st.wlast ? ST_SLA : ST_SRD;
            end
            ST_SLA:
            begin
                cmd.op     = sck_pkg::OP_SW_LA;
                state_next = ST_SLB;
            end
            ST_SLB:
            begin
                cmd.op     = sck_pkg::OP_SW_LB;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (!st.pair_last)
                begin
                    cmd.op     = sck_pkg::OP_NEXT_PAIR;
                    state_next = ST_CRD;
                end
                else if (st.swapped)
                begin
                    cmd.op     = sck_pkg::OP_NEW_PASS;
                    state_next = ST_CRD;
                end
                else
                begin
                    state_next = ST_SORT_DONE;
                end
            end
            ST_SORT_DONE:
            begin
                cmd.op     = sck_pkg::OP_SORTED;
                state_next = ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                if (st.at_end)
                begin
                    state_next = ST_END;
                end
                else
                begin
                    cmd.op     = sck_pkg::OP_SCAN_INIT;
                    state_next = ST_SC_CHK;
                end
            end
            ST_SC_CHK:
            begin
                state_next = st.scan_more ? ST_SC_RD : ST_EMIT_RD;
            end
            ST_SC_RD:
            begin
                cmd.op     = sck_pkg::OP_READ_SCAN;
                state_next = ST_SC_EV;
            end
            ST_SC_EV:
            begin
                cmd.op = sck_pkg::OP_EVAL_SCAN;
                if (st.ne)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (st.wlast)
                begin
                    state_next = ST_SC_CHK;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.op     = sck_pkg::OP_READ_EMIT;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = sck_pkg::OP_EMIT;
                    state_next = st.fin ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_END:
            begin
                if (st.out_free)
                begin
                    cmd.op     = sck_pkg::OP_END_MARK;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sck_dp.sv =====
// Datapath for sort_and_count_keys: key and length memories, counters, output register.
`timescale 1ns / 1ps
`include "sort_and_count_keys_defines.svh"
module sck_dp #(
    parameter int MAX_ENTRIES = 2048,
    parameter int KEY_WORDS   = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sck_pkg::sck_cmd_t                 cmd,
    output sck_pkg::sck_status_t              st,
    input  logic [sck_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sck_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int RB  = $clog2(MAX_ENTRIES);
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int WB  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int LW  = $clog2(KEY_WORDS + 1);
    localparam int AW  = RB + WB;
    localparam int MEM_DEPTH = 1 << AW;

    logic [63:0] key_mem [MEM_DEPTH];
    logic [LW-1:0] len_mem [MAX_ENTRIES];

    logic [EW-1:0] entry_total_reg, entry_total_next;
    logic [LW-1:0] load_pos_reg, load_pos_next;
    logic [EW-1:0] emit_pos_reg, emit_pos_next;
    logic          sorted_reg, sorted_next;
    logic [EW-1:0] i_reg, i_next;
    logic [WB-1:0] w_reg, w_next;
    logic          swapped_reg, swapped_next;
    logic [EW-1:0] cnt_reg, cnt_next;
    logic [63:0]   save_reg, save_next;
    logic          out_valid_reg, out_valid_next;
    logic [sck_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_none_reg, out_none_next;

    logic [63:0]   rda_q, rdb_q;
    logic [LW-1:0] lena_q, lenb_q;

    logic [63:0]   key_word;
    logic [3:0]    word_index;
    logic          widx_ok;
    logic [LW-1:0] widx_p1;
    logic [LW-1:0] lp_new;
    logic          load_write;
    logic [EW:0]   emit_sum;
    logic [EW-1:0] i_p1;
    logic [LW-1:0] len_eff;

    logic          key_we;
    logic [AW-1:0] key_waddr;
    logic [63:0]   key_wdata;
    logic          len_we;
    logic [RB-1:0] len_waddr;
    logic [LW-1:0] len_wdata;
    logic          rd_en;
    logic [RB-1:0] ra_row, rb_row;

    assign key_word   = s_tdata[63:0];
    assign word_index = s_tdata[67:64];
    assign widx_ok    = 6'(word_index) < 6'(KEY_WORDS);
    assign widx_p1    = LW'(word_index) + LW'(1);
    assign load_write = st.room && widx_ok;
    assign lp_new     = (load_write && (widx_p1 > load_pos_reg)) ? widx_p1 : load_pos_reg;
    assign emit_sum   = (EW+1)'(emit_pos_reg) + (EW+1)'(cnt_reg);
    assign i_p1       = i_reg + EW'(1);
    assign len_eff    = (lena_q == '0) ? LW'(1) : lena_q;

    assign st.room      = entry_total_reg < EW'(MAX_ENTRIES);
    assign st.more_room = ((EW+1)'(entry_total_reg) + (EW+1)'(1)) < (EW+1)'(MAX_ENTRIES);
    assign st.wlast     = w_reg == WB'(KEY_WORDS - 1);
    assign st.ne        = rda_q != rdb_q;
    assign st.gt        = rda_q > rdb_q;
    assign st.few       = entry_total_reg < EW'(2);
    assign st.pair_last = ((EW+1)'(i_reg) + (EW+1)'(2)) >= (EW+1)'(entry_total_reg);
    assign st.swapped   = swapped_reg;
    assign st.sorted    = sorted_reg;
    assign st.at_end    = emit_pos_reg >= entry_total_reg;
    assign st.scan_more = emit_sum < (EW+1)'(entry_total_reg);
    assign st.fin       = ((LW+1)'(w_reg) + (LW+1)'(1)) == (LW+1)'(len_eff);
    assign st.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        entry_total_next = entry_total_reg;
        load_pos_next    = load_pos_reg;
        emit_pos_next    = emit_pos_reg;
        sorted_next      = sorted_reg;
        i_next           = i_reg;
        w_next           = w_reg;
        swapped_next     = swapped_reg;
        cnt_next         = cnt_reg;
        save_next        = save_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        out_none_next    = out_none_reg;
        key_we           = 1'b0;
        key_waddr        = {entry_total_reg[RB-1:0], w_reg};
        key_wdata        = '0;
        len_we           = 1'b0;
        len_waddr        = entry_total_reg[RB-1:0];
        len_wdata        = lp_new;
        rd_en            = 1'b0;
        ra_row           = emit_pos_reg[RB-1:0];
        rb_row           = emit_sum[RB-1:0];
        case (cmd.op)
            sck_pkg::OP_CLR:
            begin
                key_we = 1'b1;
                w_next = st.wlast ? '0 : w_reg + WB'(1);
            end
            sck_pkg::OP_LOAD:
            begin
                key_we        = load_write;
                key_waddr     = {entry_total_reg[RB-1:0], WB'(word_index)};
                key_wdata     = key_word;
                load_pos_next = lp_new;
                w_next        = '0;
                if (s_tlast)
                begin
                    len_we        = st.room;
                    load_pos_next = '0;
                    if (st.room)
                    begin
                        entry_total_next = entry_total_reg + EW'(1);
                    end
                end
                sorted_next   = 1'b0;
                emit_pos_next = '0;
            end
            sck_pkg::OP_SORT_INIT, sck_pkg::OP_NEW_PASS:
            begin
                i_next       = '0;
                w_next       = '0;
                swapped_next = 1'b0;
            end
            sck_pkg::OP_READ_SORT:
            begin
                rd_en  = 1'b1;
                ra_row = i_reg[RB-1:0];
                rb_row = i_p1[RB-1:0];
            end
            sck_pkg::OP_EVAL_SORT:
            begin
                w_next = (st.ne || st.wlast) ? '0 : w_reg + WB'(1);
            end
            sck_pkg::OP_SW_WA:
            begin
                key_we    = 1'b1;
                key_waddr = {i_reg[RB-1:0], w_reg};
                key_wdata = rdb_q;
                save_next = rda_q;
            end
            sck_pkg::OP_SW_WB:
            begin
                key_we       = 1'b1;
                key_waddr    = {i_p1[RB-1:0], w_reg};
                key_wdata    = save_reg;
                swapped_next = 1'b1;
                w_next       = st.wlast ? '0 : w_reg + WB'(1);
            end
            sck_pkg::OP_SW_LA:
            begin
                len_we    = 1'b1;
                len_waddr = i_reg[RB-1:0];
                len_wdata = lenb_q;
            end
            sck_pkg::OP_SW_LB:
            begin
                len_we    = 1'b1;
                len_waddr = i_p1[RB-1:0];
                len_wdata = lena_q;
            end
            sck_pkg::OP_NEXT_PAIR:
            begin
                i_next = i_p1;
                w_next = '0;
            end
            sck_pkg::OP_SORTED:
            begin
                sorted_next   = 1'b1;
                emit_pos_next = '0;
            end
            sck_pkg::OP_SCAN_INIT:
            begin
                cnt_next = EW'(1);
                w_next   = '0;
            end
            sck_pkg::OP_READ_SCAN, sck_pkg::OP_READ_EMIT:
            begin
                rd_en = 1'b1;
            end
            sck_pkg::OP_EVAL_SCAN:
            begin
                if (st.ne)
                begin
                    w_next = '0;
                end
                else if (st.wlast)
                begin
                    cnt_next = cnt_reg + EW'(1);
                    w_next   = '0;
                end
                else
                begin
                    w_next = w_reg + WB'(1);
                end
            end
            sck_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {(st.fin ? 12'(cnt_reg) : 12'd0), 4'(w_reg), rda_q};
                out_last_next  = st.fin;
                out_none_next  = 1'b0;
                if (st.fin)
                begin
                    emit_pos_next = EW'(emit_sum);
                    w_next        = '0;
                end
                else
                begin
                    w_next = w_reg + WB'(1);
                end
            end
            sck_pkg::OP_END_MARK:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_last_next  = 1'b0;
                out_none_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            load_pos_reg    <= '0;
            emit_pos_reg    <= '0;
            sorted_reg      <= 1'b0;
            i_reg           <= '0;
            w_reg           <= '0;
            swapped_reg     <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_total_reg <= entry_total_next;
            load_pos_reg    <= load_pos_next;
            emit_pos_reg    <= emit_pos_next;
            sorted_reg      <= sorted_next;
            i_reg           <= i_next;
            w_reg           <= w_next;
            swapped_reg     <= swapped_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        save_reg     <= save_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (rd_en)
        begin
            rda_q <= key_mem[{ra_row, w_reg}];
            rdb_q <= key_mem[{rb_row, w_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (rd_en)
        begin
            lena_q <= len_mem[ra_row];
            lenb_q <= len_mem[rb_row];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_none_reg;

    `SCK_ASSERT(a_total_bound, entry_total_reg <= EW'(MAX_ENTRIES), "entry count past table size")
    `SCK_ASSERT(a_emit_word_reset, (cmd.op == sck_pkg::OP_EMIT && st.fin) |=> (w_reg == '0), "word index not rewound after group")
    `SCK_ASSERT(a_end_marker, (m_tvalid && m_tuser) |-> (!m_tlast && m_tdata == '0), "end marker carries data")
    `SCK_ASSERT(a_load_clears_sort, (cmd.op == sck_pkg::OP_LOAD) |=> (!sorted_reg && emit_pos_reg == '0), "load left sorted state")

endmodule

// ===== hdl/sort_and_count_keys.sv =====
// Top level of sort_and_count_keys: group-by-count over fixed-width text keys.
`timescale 1ns / 1ps
// Input channel s_*: tuser selects load (0) or fetch (1). A load carries one key
// word in tdata with its word index; tlast commits the key as a new table entry.
// Loads are taken one per cycle except after each commit, while the next table
// row is zeroed (also right after reset).
// A fetch sorts the table first if anything was loaded since the last sort:
// bubble passes over adjacent rows, bound by the single key memory write port.
// The run scan then compares rows word by word. Each group leaves on m_* as
// one item per key word; tlast marks the final word, which carries the count.
// A fetch with no group left gives one item with tuser high.
// No new item is taken until the fetch's last item is in the output register.
// A stalled receiver holds the output register and stops emission.
// Reset empties the table; stored keys are undefined until loaded.
module sort_and_count_keys #(
    parameter int MAX_ENTRIES = 2048,
    parameter int KEY_WORDS   = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key_word[63:0], word_index[67:64], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,   // end_of_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // group_key_word[63:0], group_word_index[67:64],
                                   // group_count[79:68]
    output logic        m_tuser,   // none_left
    output logic        m_tlast    // last
);

    sck_pkg::sck_cmd_t    cmd;
    sck_pkg::sck_status_t st;

    sck_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sck_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_WORDS   (KEY_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
